[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file afc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AFC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define AFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, always checked (reset behavior)
`define AFC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/afc_pkg.sv]
// ----------------------------------------------------------------------------
// afc_pkg
// Types and constants of the frustum culling pipeline.
// ----------------------------------------------------------------------------
package afc_pkg;

   localparam int COORD_WIDTH     = 20;
   localparam int NORM_WIDTH      = 14;
   localparam int OFFSET_WIDTH    = 22;
   localparam int FRAC_ALIGN      = 12;
   localparam int TAG_WIDTH       = 16;
   localparam int NUM_PLANES      = 6;
   localparam int PLANE_WIDTH     = 64;
   localparam int CSR_INDEX_WIDTH = $clog2(NUM_PLANES);

   localparam int PROD_WIDTH   = COORD_WIDTH + NORM_WIDTH;
   localparam int OFFS_W_WIDTH = OFFSET_WIDTH + FRAC_ALIGN;
   localparam int SUM_WIDTH    =
      ((PROD_WIDTH > OFFS_W_WIDTH) ? PROD_WIDTH : OFFS_W_WIDTH) + 2;

   typedef enum logic [1:0] {
      CLASS_INSIDE     = 2'd0,
      CLASS_INTERSECTS = 2'd1,
      CLASS_OUTSIDE    = 2'd2
   } cull_class_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] box_min_x;
      logic signed [COORD_WIDTH-1:0] box_min_y;
      logic signed [COORD_WIDTH-1:0] box_min_z;
      logic signed [COORD_WIDTH-1:0] box_max_x;
      logic signed [COORD_WIDTH-1:0] box_max_y;
      logic signed [COORD_WIDTH-1:0] box_max_z;
      logic [TAG_WIDTH-1:0]          object_tag;
   } req_type;

   typedef struct packed {
      cull_class_type       cull_class;
      logic [TAG_WIDTH-1:0] result_tag;
   } rsp_type;

   // register image: nx 63:50, ny 49:36, nz 35:22, offset 21:0
   typedef struct packed {
      logic signed [NORM_WIDTH-1:0]   nx;
      logic signed [NORM_WIDTH-1:0]   ny;
      logic signed [NORM_WIDTH-1:0]   nz;
      logic signed [OFFSET_WIDTH-1:0] offset;
   } plane_type;

   // per-stage load strobes of the datapath
   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
      logic load4;
   } pipe_en_type;

endpackage

[sv/aabb_frustum_cull.sv]
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Four register stages lie between request accept and rsp_valid, the first
// loaded on the accepting edge.
// Throughput: one box per cycle unless the output stalls; the stage chain has no loop back.
// A full stage stalls only when every stage after it is full and rsp_ready is low.
// Reset (synchronous): clears all valid bits and all six planes to zero.
// ----------------------------------------------------------------------------
module aabb_frustum_cull (
   input  logic                                clock,
   input  logic                                reset,
   // box requests
   input  logic                                req_valid,
   output logic                                req_ready,
   input  afc_pkg::req_type                    req_payload,
   // classification results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output afc_pkg::rsp_type                    rsp_payload,
   // plane register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [afc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [afc_pkg::PLANE_WIDTH-1:0]     csr_wdata
);

   // Stage map:
   //   1: corner select per normal sign, 36 products (20x14)
   //   2: pairwise sums, offset scaled by 2^12 joins here
   //   3: final distances, sign bits kept
   //   4: classify across the six planes into the output register

   afc_pkg::plane_type   planes [afc_pkg::NUM_PLANES];
   afc_pkg::pipe_en_type pipe_en;

   logic [afc_pkg::NUM_PLANES-1:0] pos_neg;
   logic [afc_pkg::NUM_PLANES-1:0] neg_neg;

   logic [afc_pkg::TAG_WIDTH-1:0] tag1_ff, tag2_ff, tag3_ff;
   afc_pkg::rsp_type              rsp_ff;
   afc_pkg::rsp_type              rsp_in;

   afc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .planes    (planes)
   );

   afc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .pipe_en   (pipe_en)
   );

   // one evaluator per plane, all in lockstep
   for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++) begin : g_plane
      afc_plane_eval u_eval (
         .clock   (clock),
         .plane   (planes[p]),
         .box     (req_payload),
         .pipe_en (pipe_en),
         .pos_neg (pos_neg[p]),
         .neg_neg (neg_neg[p])
      );
   end

   // tag rides alongside the datapath
   always_ff @(posedge clock) begin
      if (pipe_en.load1) begin
         tag1_ff <= req_payload.object_tag;
      end
      if (pipe_en.load2) begin
         tag2_ff <= tag1_ff;
      end
      if (pipe_en.load3) begin
         tag3_ff <= tag2_ff;
      end
   end

   // any far corner behind a plane -> outside; else any near corner -> straddles
   always_comb begin
      rsp_in.result_tag = tag3_ff;
      if (|pos_neg) begin
         rsp_in.cull_class = afc_pkg::CLASS_OUTSIDE;
      end else if (|neg_neg) begin
         rsp_in.cull_class = afc_pkg::CLASS_INTERSECTS;
      end else begin
         rsp_in.cull_class = afc_pkg::CLASS_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en.load4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

[sv/afc_csr.sv]
// ----------------------------------------------------------------------------
// afc_csr
// Plane register file, six 64-bit registers written over the csr channel.
// ----------------------------------------------------------------------------
module afc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [afc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [afc_pkg::PLANE_WIDTH-1:0]      csr_wdata,
   output afc_pkg::plane_type                   planes [afc_pkg::NUM_PLANES]
);

   afc_pkg::plane_type planes_ff [afc_pkg::NUM_PLANES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
            planes_ff[i] <= '0;
         end
      end else if (csr_valid &&
                   (csr_index < afc_pkg::CSR_INDEX_WIDTH'(afc_pkg::NUM_PLANES))) begin
         planes_ff[csr_index] <= afc_pkg::plane_type'(csr_wdata);
      end
   end

   assign planes = planes_ff;

endmodule

[sv/afc_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// afc_pipe_ctrl
// Valid bits and per-stage ready chain of the four-stage pipeline.
// ----------------------------------------------------------------------------
module afc_pipe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output afc_pkg::pipe_en_type pipe_en
);

   logic [3:0] valid_ff;
   logic [3:0] valid_in;
   logic [3:0] stage_ready;
   logic [3:0] upstream_valid;

   // a stage takes new data when it is empty or its content moves on
   assign stage_ready[3] = !valid_ff[3] || rsp_ready;
   assign stage_ready[2] = !valid_ff[2] || stage_ready[3];
   assign stage_ready[1] = !valid_ff[1] || stage_ready[2];
   assign stage_ready[0] = !valid_ff[0] || stage_ready[1];

   assign upstream_valid = {valid_ff[2:0], req_valid};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         valid_in[i] = stage_ready[i] ? upstream_valid[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign pipe_en.load1 = stage_ready[0] && upstream_valid[0];
   assign pipe_en.load2 = stage_ready[1] && upstream_valid[1];
   assign pipe_en.load3 = stage_ready[2] && upstream_valid[2];
   assign pipe_en.load4 = stage_ready[3] && upstream_valid[3];

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[3];

endmodule

[sv/afc_plane_eval.sv]
// ----------------------------------------------------------------------------
// afc_plane_eval
// One plane: corner select and products, partial sums, final sums and signs.
// ----------------------------------------------------------------------------
module afc_plane_eval (
   input  logic                 clock,
   input  afc_pkg::plane_type   plane,
   input  afc_pkg::req_type     box,
   input  afc_pkg::pipe_en_type pipe_en,
   output logic                 pos_neg,
   output logic                 neg_neg
);

   localparam int PW = afc_pkg::PROD_WIDTH;
   localparam int SW = afc_pkg::SUM_WIDTH;

   logic signed [afc_pkg::NORM_WIDTH-1:0]  norm   [3];
   logic signed [afc_pkg::COORD_WIDTH-1:0] lo     [3];
   logic signed [afc_pkg::COORD_WIDTH-1:0] hi     [3];
   logic signed [afc_pkg::COORD_WIDTH-1:0] pos_sel [3];
   logic signed [afc_pkg::COORD_WIDTH-1:0] neg_sel [3];
   logic signed [PW-1:0] pos_prod_in [3];
   logic signed [PW-1:0] neg_prod_in [3];
   logic signed [PW-1:0] pos_prod_ff [3];
   logic signed [PW-1:0] neg_prod_ff [3];
   logic signed [SW-1:0] offs_scaled;
   logic signed [SW-1:0] pos_a_in, pos_b_in, neg_a_in, neg_b_in;
   logic signed [SW-1:0] pos_a_ff, pos_b_ff, neg_a_ff, neg_b_ff;
   logic signed [SW-1:0] pos_sum, neg_sum;
   logic                 pos_neg_ff, neg_neg_ff;

   assign norm[0] = plane.nx;
   assign norm[1] = plane.ny;
   assign norm[2] = plane.nz;
   assign lo[0]   = box.box_min_x;
   assign lo[1]   = box.box_min_y;
   assign lo[2]   = box.box_min_z;
   assign hi[0]   = box.box_max_x;
   assign hi[1]   = box.box_max_y;
   assign hi[2]   = box.box_max_z;

   // stage 1: positive normal component picks max for the far corner
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (!norm[a][afc_pkg::NORM_WIDTH-1] && (norm[a] != '0)) begin
            pos_sel[a] = hi[a];
            neg_sel[a] = lo[a];
         end else begin
            pos_sel[a] = lo[a];
            neg_sel[a] = hi[a];
         end
         pos_prod_in[a] = PW'(pos_sel[a]) * PW'(norm[a]);
         neg_prod_in[a] = PW'(neg_sel[a]) * PW'(norm[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en.load1) begin
         pos_prod_ff <= pos_prod_in;
         neg_prod_ff <= neg_prod_in;
      end
   end

   // stage 2: two partial sums, offset aligned to 20 fraction bits
   assign offs_scaled = SW'(plane.offset) <<< afc_pkg::FRAC_ALIGN;
   assign pos_a_in = SW'(pos_prod_ff[0]) + SW'(pos_prod_ff[1]);
   assign pos_b_in = SW'(pos_prod_ff[2]) + offs_scaled;
   assign neg_a_in = SW'(neg_prod_ff[0]) + SW'(neg_prod_ff[1]);
   assign neg_b_in = SW'(neg_prod_ff[2]) + offs_scaled;

   always_ff @(posedge clock) begin
      if (pipe_en.load2) begin
         pos_a_ff <= pos_a_in;
         pos_b_ff <= pos_b_in;
         neg_a_ff <= neg_a_in;
         neg_b_ff <= neg_b_in;
      end
   end

   // stage 3: full distance, keep only the sign
   assign pos_sum = pos_a_ff + pos_b_ff;
   assign neg_sum = neg_a_ff + neg_b_ff;

   always_ff @(posedge clock) begin
      if (pipe_en.load3) begin
         pos_neg_ff <= pos_sum[SW-1];
         neg_neg_ff <= neg_sum[SW-1];
      end
   end

   assign pos_neg = pos_neg_ff;
   assign neg_neg = neg_neg_ff;

endmodule

[sv/afc_checker.sv]
// ----------------------------------------------------------------------------
// afc_checker
// Port-level checks of the culling block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input afc_pkg::rsp_type rsp_payload,
   input logic             csr_valid,
   input logic             csr_ready
);

   // stalled result holds
   `AFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // empty output stage means the whole pipe can take a request
   `AFC_ASSERT_IMPL(a_empty_ready, clock, reset, !rsp_valid, req_ready)

   // nothing comes out right after reset
   `AFC_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_valid)

   // plane writes never back-pressure
   `AFC_ASSERT_IMPL(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready)
);

[tb/tb_aabb_frustum_cull.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_frustum_cull
// Self-checking bench for the six-plane box culling pipeline. A directed
// table covers reset planes, field extremes, boundary and inverted boxes, and
// writes to unused register slots. Random plane sets and boxes follow. Every
// request is scored against an in-bench classifier or a typed-in class, with
// random stalls on both handshakes.
// ----------------------------------------------------------------------------
module tb_aabb_frustum_cull;

   localparam int COORD_WIDTH     = afc_pkg::COORD_WIDTH;
   localparam int NORM_WIDTH      = afc_pkg::NORM_WIDTH;
   localparam int OFFSET_WIDTH    = afc_pkg::OFFSET_WIDTH;
   localparam int FRAC_ALIGN      = afc_pkg::FRAC_ALIGN;
   localparam int TAG_WIDTH       = afc_pkg::TAG_WIDTH;
   localparam int NUM_PLANES      = afc_pkg::NUM_PLANES;
   localparam int PLANE_WIDTH     = afc_pkg::PLANE_WIDTH;
   localparam int CSR_INDEX_WIDTH = afc_pkg::CSR_INDEX_WIDTH;

   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 10;
   localparam int PIPE_LATENCY     = 4;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int MAX_REPORTS      = 10;
   localparam int STALL_PERCENT    = 34;
   localparam int RANDOM_PER_PHASE = 110;
   localparam int NUM_PHASES       = 5;

   // fixed-point units: 1.0 in coordinate and in normal encoding
   localparam int ONE_COORD = 1 << 8;
   localparam int ONE_NORM  = 1 << FRAC_ALIGN;

   localparam int COORD_MAX = (1 << (COORD_WIDTH - 1)) - 1;
   localparam int COORD_MIN = -(1 << (COORD_WIDTH - 1));
   localparam int NORM_MAX  = (1 << (NORM_WIDTH - 1)) - 1;
   localparam int NORM_MIN  = -(1 << (NORM_WIDTH - 1));
   localparam int OFFS_MAX  = (1 << (OFFSET_WIDTH - 1)) - 1;
   localparam int OFFS_MIN  = -(1 << (OFFSET_WIDTH - 1));

   // register map; the two top slots are decoded as don't-care
   localparam logic [CSR_INDEX_WIDTH-1:0] PLANE_NEAR   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] PLANE_FAR    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] PLANE_RIGHT  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] PLANE_LEFT   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] PLANE_TOP    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] PLANE_BOTTOM = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] SLOT_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] SLOT_SPARE_B = 3'd7;

   typedef enum logic { ROW_WRITE, ROW_BOX } row_kind_type;
   typedef enum logic [1:0] {
      PLANES_FRUSTUM, PLANES_NOISE, PLANES_EXTREME
   } plane_mix_type;

   typedef struct {
      row_kind_type                kind;
      logic [CSR_INDEX_WIDTH-1:0]  index;
      logic [PLANE_WIDTH-1:0]      wdata;
      afc_pkg::req_type            box;
      logic                        fixed;
      afc_pkg::cull_class_type     fixed_class;
   } stim_row_type;

   // ------------------------------------------------------------------------
   // DUT connections, the bench-driven ones all known from time zero
   // ------------------------------------------------------------------------
   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   afc_pkg::req_type            req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   afc_pkg::rsp_type            rsp_payload;
   logic                        csr_valid   = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index   = '0;
   logic [PLANE_WIDTH-1:0]      csr_wdata   = '0;

   // typed-in expectation riding along with the request payload
   logic                        drv_fixed       = 1'b0;
   afc_pkg::cull_class_type     drv_fixed_class = afc_pkg::CLASS_INSIDE;

   // stall control: set for one whole phase to get a stretch at full rate
   logic                        full_speed = 1'b0;

   // bench copy of the plane registers, updated on accepted writes
   afc_pkg::plane_type          plane_image [NUM_PLANES];

   afc_pkg::rsp_type            pending_results [$];
   stim_row_type                directed_rows [$];

   int                          cycle_count   = 0;
   int                          error_count   = 0;
   int                          boxes_sent    = 0;
   int                          plane_writes  = 0;
   int                          plane_sets    = 0;
   int                          class_seen [3] = '{0, 0, 0};

   aabb_frustum_cull u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Classifier: for each plane the normal signs pick the far corner (most
   // positive distance) and the near corner. Far corner behind any plane
   // means outside; else near corner behind any plane means intersects.
   // All math exact in 64 bits, offset aligned to 20 fraction bits.
   // ------------------------------------------------------------------------
   function automatic afc_pkg::cull_class_type classify_box(input afc_pkg::req_type b);
      longint                  lo [3];
      longint                  hi [3];
      longint                  nrm [3];
      longint                  far_dist;
      longint                  near_dist;
      afc_pkg::plane_type      pl;
      afc_pkg::cull_class_type verdict;
      verdict = afc_pkg::CLASS_INSIDE;
      lo[0] = $signed(b.box_min_x);
      lo[1] = $signed(b.box_min_y);
      lo[2] = $signed(b.box_min_z);
      hi[0] = $signed(b.box_max_x);
      hi[1] = $signed(b.box_max_y);
      hi[2] = $signed(b.box_max_z);
      for (int p = 0; p < NUM_PLANES; p++) begin
         // once outside, later planes can't change the verdict
         if (verdict != afc_pkg::CLASS_OUTSIDE) begin
            pl = plane_image[p];
            nrm[0] = $signed(pl.nx);
            nrm[1] = $signed(pl.ny);
            nrm[2] = $signed(pl.nz);
            far_dist  = longint'($signed(pl.offset)) * ONE_NORM;
            near_dist = far_dist;
            for (int a = 0; a < 3; a++) begin
               // zero component lands in the else arm; product is zero anyway
               if (nrm[a] > 0) begin
                  far_dist  += nrm[a] * hi[a];
                  near_dist += nrm[a] * lo[a];
               end else begin
                  far_dist  += nrm[a] * lo[a];
                  near_dist += nrm[a] * hi[a];
               end
            end
            // strict compare: zero distance counts as in front
            if (far_dist < 0)
               verdict = afc_pkg::CLASS_OUTSIDE;
            else if (near_dist < 0)
               verdict = afc_pkg::CLASS_INTERSECTS;
         end
      end
      return verdict;
   endfunction

   function automatic afc_pkg::req_type make_box(input int x0, input int y0, input int z0,
                                                 input int x1, input int y1, input int z1,
                                                 input logic [TAG_WIDTH-1:0] tag);
      afc_pkg::req_type b;
      b.box_min_x  = COORD_WIDTH'(x0);
      b.box_min_y  = COORD_WIDTH'(y0);
      b.box_min_z  = COORD_WIDTH'(z0);
      b.box_max_x  = COORD_WIDTH'(x1);
      b.box_max_y  = COORD_WIDTH'(y1);
      b.box_max_z  = COORD_WIDTH'(z1);
      b.object_tag = tag;
      return b;
   endfunction

   function automatic logic [PLANE_WIDTH-1:0] make_plane(input int nx, input int ny,
                                                        input int nz, input int d);
      afc_pkg::plane_type p;
      p.nx     = NORM_WIDTH'(nx);
      p.ny     = NORM_WIDTH'(ny);
      p.nz     = NORM_WIDTH'(nz);
      p.offset = OFFSET_WIDTH'(d);
      return p;
   endfunction

   // min, max, zero or anything in between
   function automatic int pick_edge(input int lo_v, input int hi_v);
      case ($urandom_range(3))
         0:       return lo_v;
         1:       return hi_v;
         2:       return 0;
         default: return lo_v + int'($urandom_range(hi_v - lo_v));
      endcase
   endfunction

   function automatic logic [PLANE_WIDTH-1:0] random_plane(input plane_mix_type mix);
      case (mix)
         PLANES_NOISE:
            return {$urandom, $urandom};
         PLANES_EXTREME:
            return make_plane(pick_edge(NORM_MIN, NORM_MAX), pick_edge(NORM_MIN, NORM_MAX),
                              pick_edge(NORM_MIN, NORM_MAX), pick_edge(OFFS_MIN, OFFS_MAX));
         default:
            // unit-ish normals, offset mostly keeping the origin in front
            return make_plane(int'($urandom_range(2 * ONE_NORM)) - ONE_NORM,
                              int'($urandom_range(2 * ONE_NORM)) - ONE_NORM,
                              int'($urandom_range(2 * ONE_NORM)) - ONE_NORM,
                              int'($urandom_range(400 * ONE_COORD)) - 50 * ONE_COORD);
      endcase
   endfunction

   // 80% sane boxes near the origin, 10% inverted on one axis, 10% raw bits
   function automatic afc_pkg::req_type random_box();
      afc_pkg::req_type b;
      int      pick;
      int      ax;
      int      ctr;
      int      half;
      int      tmp;
      int      lo_c [3];
      int      hi_c [3];
      pick = $urandom_range(99);
      for (int a = 0; a < 3; a++) begin
         ctr     = int'($urandom_range(600 * ONE_COORD)) - 300 * ONE_COORD;
         half    = $urandom_range(120 * ONE_COORD);
         lo_c[a] = ctr - half;
         hi_c[a] = ctr + half;
      end
      if (pick >= 80 && pick < 90) begin
         ax       = $urandom_range(2);
         tmp      = lo_c[ax];
         lo_c[ax] = hi_c[ax];
         hi_c[ax] = tmp;
      end
      b = make_box(lo_c[0], lo_c[1], lo_c[2], hi_c[0], hi_c[1], hi_c[2],
                   TAG_WIDTH'($urandom));
      if (pick >= 90) begin
         b.box_min_x = COORD_WIDTH'($urandom);
         b.box_min_y = COORD_WIDTH'($urandom);
         b.box_min_z = COORD_WIDTH'($urandom);
         b.box_max_x = COORD_WIDTH'($urandom);
         b.box_max_y = COORD_WIDTH'($urandom);
         b.box_max_z = COORD_WIDTH'($urandom);
      end
      return b;
   endfunction

   // ------------------------------------------------------------------------
   // Directed table builders
   // ------------------------------------------------------------------------
   task automatic add_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [PLANE_WIDTH-1:0] data);
      stim_row_type r;
      r.kind        = ROW_WRITE;
      r.index       = idx;
      r.wdata       = data;
      r.box         = '0;
      r.fixed       = 1'b0;
      r.fixed_class = afc_pkg::CLASS_INSIDE;
      directed_rows.push_back(r);
   endtask

   task automatic add_box(input afc_pkg::req_type b, input logic fixed,
                          input afc_pkg::cull_class_type cls);
      stim_row_type r;
      r.kind        = ROW_BOX;
      r.index       = '0;
      r.wdata       = '0;
      r.box         = b;
      r.fixed       = fixed;
      r.fixed_class = cls;
      directed_rows.push_back(r);
   endtask

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic push_box(input afc_pkg::req_type b, input logic fixed,
                           input afc_pkg::cull_class_type cls);
      // optional idle gap before presenting the request
      if (!full_speed && $urandom_range(99) < STALL_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < STALL_PERCENT)
            @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_payload     <= b;
      drv_fixed       <= fixed;
      drv_fixed_class <= cls;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      boxes_sent++;
   endtask

   // wait for every outstanding result, then let the pipe settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 4)
         @(posedge clock);
   endtask

   task automatic write_plane(input logic [CSR_INDEX_WIDTH-1:0] idx,
                              input logic [PLANE_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_planes(input plane_mix_type mix);
      for (int i = 0; i < NUM_PLANES; i++)
         write_plane(CSR_INDEX_WIDTH'(i), random_plane(mix));
      // junk into a spare slot now and then; must not disturb anything
      if (mix == PLANES_NOISE || $urandom_range(1) == 1)
         write_plane($urandom_range(1) ? SLOT_SPARE_B : SLOT_SPARE_A, {$urandom, $urandom});
      plane_sets++;
   endtask

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // ------------------------------------------------------------------------
   // Result side: random backpressure
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= full_speed || ($urandom_range(99) >= STALL_PERCENT);
   end

   // ------------------------------------------------------------------------
   // Scoreboard: one process handles plane writes, accepted requests and
   // returned results, in that order, so nothing hinges on process ordering.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      afc_pkg::rsp_type want;
      afc_pkg::rsp_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            plane_writes++;
            if (csr_index < NUM_PLANES)
               plane_image[csr_index] = csr_wdata;
         end
         if (req_valid && req_ready) begin
            want.cull_class = drv_fixed ? drv_fixed_class : classify_box(req_payload);
            want.result_tag = req_payload.object_tag;
            pending_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (got.cull_class <= afc_pkg::CLASS_OUTSIDE)
               class_seen[got.cull_class]++;
            if (pending_results.size() == 0) begin
               flag_error($sformatf("unexpected result class %0d tag %h",
                                    got.cull_class, got.result_tag));
            end else begin
               want = pending_results.pop_front();
               if (got.cull_class !== want.cull_class)
                  flag_error($sformatf("tag %h class exp %0d got %0d",
                                       want.result_tag, want.cull_class, got.cull_class));
               if (got.result_tag !== want.result_tag)
                  flag_error($sformatf("tag exp %h got %h", want.result_tag, got.result_tag));
            end
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      plane_mix_type phase_mix [NUM_PHASES];
      phase_mix = '{PLANES_FRUSTUM, PLANES_NOISE, PLANES_FRUSTUM,
                    PLANES_EXTREME, PLANES_FRUSTUM};
      foreach (plane_image[i])
         plane_image[i] = '0;

      // all planes zero after reset: every distance is zero -> inside
      add_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                       16'h0000), 1'b1, afc_pkg::CLASS_INSIDE);
      add_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                       16'hFFFF), 1'b1, afc_pkg::CLASS_INSIDE);
      add_box(make_box(0, 0, 0, 0, 0, 0, 16'hA5A5), 1'b1, afc_pkg::CLASS_INSIDE);

      // zero normal, offset just below zero: nothing survives
      add_write(PLANE_NEAR, make_plane(0, 0, 0, -1));
      add_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                       16'h5A5A), 1'b1, afc_pkg::CLASS_OUTSIDE);
      add_box(make_box(0, 0, 0, 0, 0, 0, 16'h0001), 1'b1, afc_pkg::CLASS_OUTSIDE);

      // zero normal, positive offset: everything inside again
      add_write(PLANE_NEAR, make_plane(0, 0, 0, 1));
      add_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                       16'h0002), 1'b1, afc_pkg::CLASS_INSIDE);

      // axis-aligned cube |x|,|y|,|z| <= 100, spare slots loaded with ones
      add_write(PLANE_NEAR,   make_plane(0, 0, ONE_NORM, 100 * ONE_COORD));
      add_write(PLANE_FAR,    make_plane(0, 0, -ONE_NORM, 100 * ONE_COORD));
      add_write(PLANE_RIGHT,  make_plane(-ONE_NORM, 0, 0, 100 * ONE_COORD));
      add_write(PLANE_LEFT,   make_plane(ONE_NORM, 0, 0, 100 * ONE_COORD));
      add_write(PLANE_TOP,    make_plane(0, -ONE_NORM, 0, 100 * ONE_COORD));
      add_write(PLANE_BOTTOM, make_plane(0, ONE_NORM, 0, 100 * ONE_COORD));
      add_write(SLOT_SPARE_A, '1);
      add_write(SLOT_SPARE_B, '1);
      add_box(make_box(-10 * ONE_COORD, -10 * ONE_COORD, -10 * ONE_COORD,
                       10 * ONE_COORD, 10 * ONE_COORD, 10 * ONE_COORD, 16'h0010),
              1'b0, afc_pkg::CLASS_INSIDE);
      add_box(make_box(90 * ONE_COORD, 0, 0, 110 * ONE_COORD, ONE_COORD, ONE_COORD, 16'h0011),
              1'b0, afc_pkg::CLASS_INSIDE);
      add_box(make_box(200 * ONE_COORD, 0, 0, 300 * ONE_COORD, ONE_COORD, ONE_COORD,
                       16'h0012), 1'b0, afc_pkg::CLASS_INSIDE);
      // face exactly on the plane: distance zero is not behind it
      add_box(make_box(50 * ONE_COORD, 0, 0, 100 * ONE_COORD, ONE_COORD, ONE_COORD,
                       16'h0013), 1'b0, afc_pkg::CLASS_INSIDE);
      // inverted on x, used as given
      add_box(make_box(50 * ONE_COORD, -10 * ONE_COORD, -10 * ONE_COORD,
                       -50 * ONE_COORD, 10 * ONE_COORD, 10 * ONE_COORD, 16'h0014),
              1'b0, afc_pkg::CLASS_INSIDE);
      // off the corner region, beyond two planes at once
      add_box(make_box(101 * ONE_COORD, 101 * ONE_COORD, 0, 150 * ONE_COORD,
                       150 * ONE_COORD, ONE_COORD, 16'h0015), 1'b0, afc_pkg::CLASS_INSIDE);
      add_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                       16'h0016), 1'b0, afc_pkg::CLASS_INSIDE);
      add_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                       16'h0017), 1'b0, afc_pkg::CLASS_INSIDE);
      add_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                       16'h0018), 1'b0, afc_pkg::CLASS_INSIDE);

      // extreme normals and offsets, largest products and sums
      add_write(PLANE_NEAR,   make_plane(NORM_MAX, NORM_MIN, 0, OFFS_MAX));
      add_write(PLANE_FAR,    make_plane(NORM_MIN, NORM_MAX, NORM_MAX, OFFS_MIN));
      add_write(PLANE_RIGHT,  make_plane(NORM_MAX, NORM_MAX, NORM_MAX, 0));
      add_write(PLANE_LEFT,   make_plane(NORM_MIN, NORM_MIN, NORM_MIN, 0));
      add_write(PLANE_TOP,    make_plane(0, 0, 0, OFFS_MAX));
      add_write(PLANE_BOTTOM, make_plane(1, -1, 0, 0));
      add_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                       16'h0020), 1'b0, afc_pkg::CLASS_INSIDE);
      add_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                       16'h0021), 1'b0, afc_pkg::CLASS_INSIDE);
      add_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                       16'h0022), 1'b0, afc_pkg::CLASS_INSIDE);
      add_box(make_box(0, 0, 0, 0, 0, 0, 16'h0023), 1'b0, afc_pkg::CLASS_INSIDE);

      // every register bit set on one plane
      add_write(PLANE_NEAR, '1);
      add_box(make_box(0, 0, 0, 0, 0, 0, 16'h0024), 1'b0, afc_pkg::CLASS_INSIDE);

      // back to all zero planes
      for (int i = 0; i < NUM_PLANES; i++)
         add_write(CSR_INDEX_WIDTH'(i), '0);
      add_box(make_box(COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, 0, 16'h0025),
              1'b1, afc_pkg::CLASS_INSIDE);

      repeat (RESET_CYCLES)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; plane writes only once the pipe is empty
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain_results();
            write_plane(directed_rows[i].index, directed_rows[i].wdata);
         end else begin
            push_box(directed_rows[i].box, directed_rows[i].fixed,
                     directed_rows[i].fixed_class);
         end
      end
      drain_results();

      // random phases, each under a fresh plane set; third one runs unstalled
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         load_planes(phase_mix[ph]);
         full_speed <= (ph == 2);
         repeat (RANDOM_PER_PHASE)
            push_box(random_box(), 1'b0, afc_pkg::CLASS_INSIDE);
         drain_results();
      end
      full_speed <= 1'b0;

      $display("run: %0d boxes, %0d register writes, %0d random plane sets",
               boxes_sent, plane_writes, plane_sets);
      $display("classes returned: inside %0d, intersects %0d, outside %0d, errors %0d",
               class_seen[afc_pkg::CLASS_INSIDE], class_seen[afc_pkg::CLASS_INTERSECTS],
               class_seen[afc_pkg::CLASS_OUTSIDE], error_count);
      if (error_count == 0 && pending_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
